// ===== sv/snie_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted node index package
// Shared types, sizes and codes for the sorted node index with eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package snie_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > 10) ? $clog2(TABLE_DEPTH + 1) : 10;
  localparam int TOTAL_W = 10;
  localparam int LIMIT_W = 10;
  localparam int LIMIT_RESET = 512;

  localparam int IN_TDATA_W = 128;
  localparam int OUT_TDATA_W = 160;

  localparam int FLAG_PROT = 0;
  localparam int FLAG_CACH = 1;
  localparam int FLAG_DIRT = 2;

  typedef enum logic [3:0] {
    ACT_LOOKUP   = 4'd0,
    ACT_INSERT   = 4'd1,
    ACT_REMOVE   = 4'd2,
    ACT_SET_TIME = 4'd3,
    ACT_ACCESS   = 4'd4,
    ACT_SET_FLAG = 4'd5,
    ACT_EVICT    = 4'd6,
    ACT_READ_POS = 4'd7,
    ACT_CLEAR    = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CHOICE_PROT = 2'd0,
    CHOICE_CACH = 2'd1,
    CHOICE_DIRT = 2'd2,
    CHOICE_NONE = 2'd3
  } choice_t;

  typedef struct packed {
    logic [31:0] accesses;
    logic [31:0] heard;
    logic [2:0]  flags;
    logic [15:0] slot;
    logic [31:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_ACT,
    S_SHIFT,
    S_PLACE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/snie_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module snie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sorted_node_index_with_eviction.sv =====
// ----------------------------------------------------------------------------
// Sorted node index with eviction
// Table of node entries kept sorted by id, with a single-port sequencer.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream (action in s_tuser) and each transaction gives
// exactly one result transaction on the m_ stream (status in m_tuser). The
// limit register is written over the cfg_ channel, which is always ready.
// One item is worked on at a time; s_tready is high only while the sequencer
// is idle. All work goes through one RAM with one read and one write a cycle.
// Lookup, set time, count access and set flag take a binary search, each
// step a read and a compare. Insert and remove add a shift of the entries
// behind the position, one entry a cycle. An eviction query or a scan
// reads every entry once. Read by position reads one entry, clear only
// zeroes the count and totals. The result sits in an output register, so a
// stalled receiver holds the next item back only at the end of its work.
// Reset empties the table and sets the limit to 512; there is no clearing
// pass, entries past the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_node_index_with_eviction (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // node_id, slot_number, heard_time, flag_choice, flag_value, allow_cached,
  // time_is_valid, current_time, table_position, zero fill
  input  wire logic [snie_pkg::IN_TDATA_W-1:0]   s_tdata,
  // action
  input  wire logic [3:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // found_node, found_slot, found_flags, found_time, found_accesses,
  // entry_total, cached_total, protected_total, dirty_total, zero fill
  output logic      [snie_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // status
  output logic      [1:0]                        m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [snie_pkg::LIMIT_W-1:0]      cfg_data
);

  import snie_pkg::*;

  state_t state, state_next;

  action_t      act;
  logic [31:0]  key;
  logic [15:0]  in_slot;
  logic [31:0]  in_heard;
  logic [1:0]   in_choice;
  logic         in_fval;
  logic         in_allow;
  logic         in_tvalid;
  logic [31:0]  in_now;

  logic [CNT_W-1:0] occ, ccnt, pcnt, dcnt;
  logic [LIMIT_W-1:0] lim;
  logic [CNT_W-1:0] lo, hi, mid, pos, cursor;
  logic [IDX_W-1:0] wr_ptr, sc_idx;
  logic             found, have_data, rd_more;
  entry_t           entry, best_ent, res_ent, out_ent, mod_ent, rd_ent, new_ent;
  logic [31:0]      best_pr, pr;
  logic             best_hit, take, elig;
  status_t          res_status, out_status;
  logic [CNT_W-1:0] out_occ, out_ccnt, out_pcnt, out_dcnt;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_c, lim_ext, lim_eff, tpos_ext;
  logic             accept, out_free, walk_end;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  snie_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign walk_end  = !rd_more && !have_data;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_c     = mid_sum[CNT_W:1];
  assign lim_ext   = CNT_W'(lim);
  assign lim_eff   = (lim_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : lim_ext;
  assign tpos_ext  = CNT_W'(s_tdata[125:117]);

  always_comb begin
    new_ent          = '0;
    new_ent.id       = key;
    new_ent.slot     = in_slot;
  end

  always_comb begin
    mod_ent = entry;
    case (act)
      ACT_SET_TIME: mod_ent.heard = in_heard;
      ACT_ACCESS: begin
        if (entry.accesses != 32'hFFFF_FFFF) begin
          mod_ent.accesses = entry.accesses + 32'd1;
        end
      end
      ACT_SET_FLAG: begin
        case (choice_t'(in_choice))
          CHOICE_PROT: mod_ent.flags[FLAG_PROT] = in_fval;
          CHOICE_CACH: mod_ent.flags[FLAG_CACH] = in_fval;
          CHOICE_DIRT: mod_ent.flags[FLAG_DIRT] = in_fval;
          default: mod_ent.flags = entry.flags;
        endcase
      end
      default: mod_ent = entry;
    endcase
  end

  always_comb begin
    elig = !rd_ent.flags[FLAG_PROT] && (in_allow || !rd_ent.flags[FLAG_CACH]);
    if (in_tvalid && rd_ent.heard != 32'd0) begin
      pr = (rd_ent.heard > in_now) ? 32'd0 : rd_ent.heard;
    end else if (rd_ent.accesses != 32'd0) begin
      pr = rd_ent.accesses;
    end else begin
      pr = 32'(sc_idx);
    end
    take = have_data && elig && (!best_hit || pr < best_pr);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            ACT_LOOKUP, ACT_INSERT, ACT_REMOVE, ACT_SET_TIME, ACT_ACCESS,
            ACT_SET_FLAG: state_next = S_SRCH;
            ACT_EVICT:    state_next = (occ == '0) ? S_DONE : S_SCAN;
            ACT_READ_POS: state_next = (tpos_ext < occ) ? S_READ : S_DONE;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_SRCH: state_next = (lo < hi) ? S_SCMP : S_ACT;
      S_SCMP: state_next = (rd_ent.id == key) ? S_ACT : S_SRCH;
      S_ACT: begin
        case (act)
          ACT_INSERT: begin
            if (found || occ >= lim_eff) begin
              state_next = S_DONE;
            end else if (pos == occ) begin
              state_next = S_PLACE;
            end else begin
              state_next = S_SHIFT;
            end
          end
          ACT_REMOVE: state_next = (found && (pos + 1'b1 < occ)) ? S_SHIFT : S_DONE;
          default:    state_next = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (walk_end) begin
          state_next = (act == ACT_INSERT) ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: state_next = S_DONE;
      S_SCAN:  state_next = walk_end ? S_DONE : S_SCAN;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = rd_ent;
    ram_raddr = IDX_W'(cursor);
    unique case (state)
      S_IDLE:  ram_raddr = IDX_W'(tpos_ext);
      S_SRCH:  ram_raddr = IDX_W'(mid_c);
      S_ACT: begin
        ram_waddr = IDX_W'(pos);
        ram_wdata = mod_ent;
        ram_we    = found && (act == ACT_SET_TIME || act == ACT_ACCESS ||
                              act == ACT_SET_FLAG);
      end
      S_SHIFT: ram_we = have_data;
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(pos);
        ram_wdata = new_ent;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      ccnt      <= '0;
      pcnt      <= '0;
      dcnt      <= '0;
      lim       <= LIMIT_W'(LIMIT_RESET);
      m_tvalid  <= 1'b0;
      have_data <= 1'b0;
      rd_more   <= 1'b0;
      best_hit  <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        lim <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act        <= action_t'(s_tuser);
            key        <= s_tdata[31:0];
            in_slot    <= s_tdata[47:32];
            in_heard   <= s_tdata[79:48];
            in_choice  <= s_tdata[81:80];
            in_fval    <= s_tdata[82];
            in_allow   <= s_tdata[83];
            in_tvalid  <= s_tdata[84] && (s_tdata[116:85] != 32'd0);
            in_now     <= s_tdata[116:85];
            lo         <= '0;
            hi         <= occ;
            found      <= 1'b0;
            cursor     <= '0;
            rd_more    <= 1'b1;
            have_data  <= 1'b0;
            best_hit   <= 1'b0;
            res_status <= (s_tuser == ACT_CLEAR) ? ST_OK : ST_NONE;
            res_ent    <= '0;
            if (s_tuser == ACT_CLEAR) begin
              occ        <= '0;
              ccnt       <= '0;
              pcnt       <= '0;
              dcnt       <= '0;
            end
          end
        end
        S_SRCH: begin
          mid <= mid_c;
          if (lo >= hi) begin
            pos <= lo;
          end
        end
        S_SCMP: begin
          if (rd_ent.id == key) begin
            found <= 1'b1;
            pos   <= mid;
            entry <= rd_ent;
          end else if (rd_ent.id < key) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        S_ACT: begin
          case (act)
            ACT_INSERT: begin
              if (found) begin
                res_status <= ST_PRESENT;
              end else if (occ >= lim_eff) begin
                res_status <= ST_FULL;
              end else begin
                cursor    <= occ - 1'b1;
                rd_more   <= 1'b1;
                have_data <= 1'b0;
              end
            end
            ACT_REMOVE: begin
              if (found) begin
                res_status <= ST_OK;
                res_ent    <= entry;
                occ        <= occ - 1'b1;
                ccnt       <= ccnt - CNT_W'(entry.flags[FLAG_CACH]);
                pcnt       <= pcnt - CNT_W'(entry.flags[FLAG_PROT]);
                dcnt       <= dcnt - CNT_W'(entry.flags[FLAG_DIRT]);
                cursor     <= pos + 1'b1;
                rd_more    <= 1'b1;
                have_data  <= 1'b0;
              end
            end
            default: begin
              if (found) begin
                res_status <= ST_OK;
                res_ent    <= mod_ent;
                ccnt <= ccnt - CNT_W'(entry.flags[FLAG_CACH])
                             + CNT_W'(mod_ent.flags[FLAG_CACH]);
                pcnt <= pcnt - CNT_W'(entry.flags[FLAG_PROT])
                             + CNT_W'(mod_ent.flags[FLAG_PROT]);
                dcnt <= dcnt - CNT_W'(entry.flags[FLAG_DIRT])
                             + CNT_W'(mod_ent.flags[FLAG_DIRT]);
              end
            end
          endcase
        end
        S_SHIFT: begin
          if (rd_more) begin
            have_data <= 1'b1;
            if (act == ACT_INSERT) begin
              wr_ptr  <= IDX_W'(cursor + 1'b1);
              cursor  <= cursor - 1'b1;
              rd_more <= (cursor != pos);
            end else begin
              wr_ptr  <= IDX_W'(cursor - 1'b1);
              cursor  <= cursor + 1'b1;
              rd_more <= (cursor != occ);
            end
          end else begin
            have_data <= 1'b0;
          end
        end
        S_PLACE: begin
          occ        <= occ + 1'b1;
          res_status <= ST_OK;
          res_ent    <= new_ent;
        end
        S_SCAN: begin
          if (take) begin
            best_hit <= 1'b1;
            best_pr  <= pr;
            best_ent <= rd_ent;
          end
          if (rd_more) begin
            have_data <= 1'b1;
            sc_idx    <= IDX_W'(cursor);
            cursor    <= cursor + 1'b1;
            rd_more   <= (cursor + 1'b1 != occ);
          end else begin
            have_data <= 1'b0;
          end
          if (walk_end && best_hit) begin
            res_status <= ST_OK;
            res_ent    <= best_ent;
          end
        end
        S_READ: begin
          res_status <= ST_OK;
          res_ent    <= rd_ent;
        end
        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_ent    <= res_ent;
            out_occ    <= occ;
            out_ccnt   <= ccnt;
            out_pcnt   <= pcnt;
            out_dcnt   <= dcnt;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'd0,
                    TOTAL_W'(out_dcnt), TOTAL_W'(out_pcnt),
                    TOTAL_W'(out_ccnt), TOTAL_W'(out_occ),
                    out_ent.accesses, out_ent.heard, out_ent.flags,
                    out_ent.slot, out_ent.id};

endmodule

`default_nettype wire

// ===== sv/snie_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted node index checker
// Port-level assertions for the sorted node index, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module snie_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [snie_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [1:0]                       m_tuser
);

  import snie_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new transaction taken while an item is in work");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[124:115] <= TOTAL_W'(TABLE_DEPTH))
    else $error("entry total beyond table depth");

  a_cached_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[134:125] <= m_tdata[124:115])
    else $error("cached total beyond entry total");

endmodule

bind sorted_node_index_with_eviction snie_checker u_snie_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
